// File: rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

    localparam int HUE_W   = 16;
    localparam int CHAN_W  = 8;
    localparam int DEG_W   = 9;
    localparam int QUOT_W  = 8;
    localparam int REM_W   = 8;
    localparam int PROD_W  = 2 * CHAN_W;

    // floor(hue / 360) within one of (hue * HUE_RECIP) >> HUE_RECIP_SHIFT, never above
    localparam int HUE_RECIP_W     = 16;
    localparam int HUE_RECIP_SHIFT = 24;
    localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = HUE_RECIP_W'(46603);

    localparam logic [DEG_W-1:0] DEG_FULL   = DEG_W'(360);
    localparam logic [DEG_W-1:0] DEG_SECTOR = DEG_W'(60);

    localparam logic [CHAN_W-1:0] CHAN_MAX  = CHAN_W'(255);
    localparam logic [REM_W:0]    RAMP_FULL = (REM_W + 1)'(256);

    localparam int STAGES = 8;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

endpackage

// File: rtl/hsv_to_rgb_converter_core.sv
// HSV to 8-bit RGB converter. One colour item enters per clock unless the output stalls;
// the eight-stage pipeline (hue modulo, sector split, three multiplies, two reciprocal
// divides by 255 with correction, channel select) holds up to eight items
// in flight. Each stage advances when it is empty or the stage after it advances, so a
// stall on the output fills bubbles first and drops or repeats nothing. Any 16-bit hue is
// valid and is reduced modulo 360. Zero saturation yields red = green = blue = value.
module hsv_to_rgb_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[15:0], saturation[23:16], brightness_value[31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int CW = hsvrgb_pkg::CHAN_W;
    localparam int PW = hsvrgb_pkg::PROD_W;
    localparam int DW = hsvrgb_pkg::DEG_W;
    localparam int RW = hsvrgb_pkg::REM_W;
    localparam int NS = hsvrgb_pkg::STAGES;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    logic [hsvrgb_pkg::HUE_W-1:0]     hue_in;
    logic [CW-1:0]                    sat_in;
    logic [CW-1:0]                    val_in;

    // stage 1
    logic [hsvrgb_pkg::HUE_W-1:0]     hue_s1_reg;
    logic [CW-1:0]                    sat_s1_reg;
    logic [CW-1:0]                    val_s1_reg;
    logic [hsvrgb_pkg::QUOT_W-1:0]    quot_s1_reg;
    logic [hsvrgb_pkg::HUE_W+hsvrgb_pkg::HUE_RECIP_W-1:0] quot_prod;

    // stage 2
    logic [DW-1:0]                    deg_s2_reg;
    logic [CW-1:0]                    sat_s2_reg;
    logic [CW-1:0]                    val_s2_reg;
    logic [hsvrgb_pkg::HUE_W:0]       deg_diff;
    logic [DW-1:0]                    deg_next;

    // stage 3
    hsvrgb_pkg::sector_t              sec_s3_reg;
    logic [RW-1:0]                    ramp_s3_reg;
    logic [CW-1:0]                    sat_s3_reg;
    logic [CW-1:0]                    val_s3_reg;
    hsvrgb_pkg::sector_t              sec_next;
    logic [DW-1:0]                    sec_base;
    logic [DW-1:0]                    ramp_deg;
    logic [RW-1:0]                    ramp_next;

    // stage 4
    hsvrgb_pkg::sector_t              sec_s4_reg;
    logic [CW-1:0]                    val_s4_reg;
    logic [PW-1:0]                    pnum_s4_reg;
    logic [PW-1:0]                    tnum_s4_reg;
    logic [RW:0]                      ramp_mult;

    // stage 5
    hsvrgb_pkg::sector_t              sec_s5_reg;
    logic [CW-1:0]                    val_s5_reg;
    logic [PW-1:0]                    pnum_s5_reg;
    logic [CW-1:0]                    pest_s5_reg;
    logic [CW-1:0]                    temp_s5_reg;
    logic [PW+CW:0]                   pest_sum;

    // stage 6
    hsvrgb_pkg::sector_t              sec_s6_reg;
    logic [CW-1:0]                    val_s6_reg;
    logic [CW-1:0]                    p_s6_reg;
    logic [PW-1:0]                    vnum_s6_reg;
    logic [PW:0]                      prem;
    logic [CW-1:0]                    p_next;

    // stage 7
    hsvrgb_pkg::sector_t              sec_s7_reg;
    logic [CW-1:0]                    val_s7_reg;
    logic [CW-1:0]                    p_s7_reg;
    logic [PW-1:0]                    vnum_s7_reg;
    logic [CW-1:0]                    vest_s7_reg;
    logic [PW+CW:0]                   vest_sum;

    // stage 8 (output)
    logic [CW-1:0]                    red_reg;
    logic [CW-1:0]                    green_reg;
    logic [CW-1:0]                    blue_reg;
    logic [PW:0]                      vrem;
    logic [CW-1:0]                    vary;
    logic [CW-1:0]                    red_next;
    logic [CW-1:0]                    green_next;
    logic [CW-1:0]                    blue_next;

    assign hue_in = s_axis_tdata[15:0];
    assign sat_in = s_axis_tdata[23:16];
    assign val_in = s_axis_tdata[31:24];

    // stage advance chain
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: reciprocal estimate of hue / 360
    assign quot_prod = hue_in * hsvrgb_pkg::HUE_RECIP;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hue_s1_reg  <= hue_in;
            sat_s1_reg  <= sat_in;
            val_s1_reg  <= val_in;
            quot_s1_reg <= quot_prod[hsvrgb_pkg::HUE_RECIP_SHIFT +: hsvrgb_pkg::QUOT_W];
        end
    end

    // stage 2: hue mod 360 with one correction
    always_comb
    begin
        deg_diff = {1'b0, hue_s1_reg}
                 - ((hsvrgb_pkg::HUE_W + 1)'(quot_s1_reg)
                    * (hsvrgb_pkg::HUE_W + 1)'(hsvrgb_pkg::DEG_FULL));
        if (deg_diff >= (hsvrgb_pkg::HUE_W + 1)'(hsvrgb_pkg::DEG_FULL))
        begin
            deg_next = DW'(deg_diff - (hsvrgb_pkg::HUE_W + 1)'(hsvrgb_pkg::DEG_FULL));
        end
        else
        begin
            deg_next = DW'(deg_diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            deg_s2_reg <= deg_next;
            sat_s2_reg <= sat_s1_reg;
            val_s2_reg <= val_s1_reg;
        end
    end

    // stage 3: sector and ramp position
    always_comb
    begin
        if (deg_s2_reg >= DW'(5) * hsvrgb_pkg::DEG_SECTOR)
        begin
            sec_next = hsvrgb_pkg::SEC_MAG_RED;
            sec_base = DW'(5) * hsvrgb_pkg::DEG_SECTOR;
        end
        else if (deg_s2_reg >= DW'(4) * hsvrgb_pkg::DEG_SECTOR)
        begin
            sec_next = hsvrgb_pkg::SEC_BLU_MAG;
            sec_base = DW'(4) * hsvrgb_pkg::DEG_SECTOR;
        end
        else if (deg_s2_reg >= DW'(3) * hsvrgb_pkg::DEG_SECTOR)
        begin
            sec_next = hsvrgb_pkg::SEC_CYN_BLU;
            sec_base = DW'(3) * hsvrgb_pkg::DEG_SECTOR;
        end
        else if (deg_s2_reg >= DW'(2) * hsvrgb_pkg::DEG_SECTOR)
        begin
            sec_next = hsvrgb_pkg::SEC_GRN_CYN;
            sec_base = DW'(2) * hsvrgb_pkg::DEG_SECTOR;
        end
        else if (deg_s2_reg >= hsvrgb_pkg::DEG_SECTOR)
        begin
            sec_next = hsvrgb_pkg::SEC_YEL_GRN;
            sec_base = hsvrgb_pkg::DEG_SECTOR;
        end
        else
        begin
            sec_next = hsvrgb_pkg::SEC_RED_YEL;
            sec_base = '0;
        end
        ramp_deg  = deg_s2_reg - sec_base;
        ramp_next = {ramp_deg[RW-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sec_s3_reg  <= sec_next;
            ramp_s3_reg <= ramp_next;
            sat_s3_reg  <= sat_s2_reg;
            val_s3_reg  <= val_s2_reg;
        end
    end

    // stage 4: products for p and temp
    always_comb
    begin
        if (sec_s3_reg[0])
        begin
            ramp_mult = {1'b0, ramp_s3_reg};
        end
        else
        begin
            ramp_mult = hsvrgb_pkg::RAMP_FULL - {1'b0, ramp_s3_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sec_s4_reg  <= sec_s3_reg;
            val_s4_reg  <= val_s3_reg;
            pnum_s4_reg <= val_s3_reg * (hsvrgb_pkg::CHAN_MAX - sat_s3_reg);
            tnum_s4_reg <= PW'(sat_s3_reg) * PW'(ramp_mult);
        end
    end

    // stage 5: temp and first estimate of p
    assign pest_sum = {pnum_s4_reg, {CW{1'b0}}} + (PW + CW + 1)'(pnum_s4_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sec_s5_reg  <= sec_s4_reg;
            val_s5_reg  <= val_s4_reg;
            pnum_s5_reg <= pnum_s4_reg;
            pest_s5_reg <= pest_sum[PW +: CW];
            temp_s5_reg <= tnum_s4_reg[PW-1:CW];
        end
    end

    // stage 6: correct p, product for the varying channel
    always_comb
    begin
        prem = {1'b0, pnum_s5_reg} - {1'b0, pest_s5_reg, {CW{1'b0}}} + (PW + 1)'(pest_s5_reg);
        if (prem >= (PW + 1)'(hsvrgb_pkg::CHAN_MAX))
        begin
            p_next = pest_s5_reg + CW'(1);
        end
        else
        begin
            p_next = pest_s5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            sec_s6_reg  <= sec_s5_reg;
            val_s6_reg  <= val_s5_reg;
            p_s6_reg    <= p_next;
            vnum_s6_reg <= val_s5_reg * (hsvrgb_pkg::CHAN_MAX - temp_s5_reg);
        end
    end

    // stage 7: first estimate of the varying channel
    assign vest_sum = {vnum_s6_reg, {CW{1'b0}}} + (PW + CW + 1)'(vnum_s6_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            sec_s7_reg  <= sec_s6_reg;
            val_s7_reg  <= val_s6_reg;
            p_s7_reg    <= p_s6_reg;
            vnum_s7_reg <= vnum_s6_reg;
            vest_s7_reg <= vest_sum[PW +: CW];
        end
    end

    // stage 8: correct varying channel, route channels
    always_comb
    begin
        vrem = {1'b0, vnum_s7_reg} - {1'b0, vest_s7_reg, {CW{1'b0}}} + (PW + 1)'(vest_s7_reg);
        if (vrem >= (PW + 1)'(hsvrgb_pkg::CHAN_MAX))
        begin
            vary = vest_s7_reg + CW'(1);
        end
        else
        begin
            vary = vest_s7_reg;
        end
        case (sec_s7_reg)
            hsvrgb_pkg::SEC_RED_YEL:
            begin
                red_next   = val_s7_reg;
                green_next = vary;
                blue_next  = p_s7_reg;
            end
            hsvrgb_pkg::SEC_YEL_GRN:
            begin
                red_next   = vary;
                green_next = val_s7_reg;
                blue_next  = p_s7_reg;
            end
            hsvrgb_pkg::SEC_GRN_CYN:
            begin
                red_next   = p_s7_reg;
                green_next = val_s7_reg;
                blue_next  = vary;
            end
            hsvrgb_pkg::SEC_CYN_BLU:
            begin
                red_next   = p_s7_reg;
                green_next = vary;
                blue_next  = val_s7_reg;
            end
            hsvrgb_pkg::SEC_BLU_MAG:
            begin
                red_next   = vary;
                green_next = p_s7_reg;
                blue_next  = val_s7_reg;
            end
            default:
            begin
                red_next   = val_s7_reg;
                green_next = p_s7_reg;
                blue_next  = vary;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

// File: tb/sv/tb_hsv_to_rgb_converter_core.sv
module tb_hsv_to_rgb_converter_core;

    localparam int HUE_W       = hsvrgb_pkg::HUE_W;
    localparam int CHAN_W      = hsvrgb_pkg::CHAN_W;
    localparam int N_DIRECTED  = 22;
    localparam int N_RANDOM    = 1800;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 4 * hsvrgb_pkg::STAGES;

    typedef struct packed {
        logic [CHAN_W-1:0] brightness_value;
        logic [CHAN_W-1:0] saturation;
        logic [HUE_W-1:0]  hue;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        logic              pinned;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } colour_row_t;

    typedef struct {
        bit   pinned;
        rgb_t rgb;
    } known_rgb_t;

    // pinned rows carry a typed-in result, the rest go through the predictor
    localparam colour_row_t COLOUR_TABLE [N_DIRECTED] = '{
        '{16'd0,     8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{16'd0,     8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        '{16'd65535, 8'd0,   8'd128, 1'b1, 8'd128, 8'd128, 8'd128},
        '{16'd0,     8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{16'd0,     8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{16'd60,    8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
        '{16'd120,   8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
        '{16'd180,   8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
        '{16'd240,   8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
        '{16'd300,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
        '{16'd360,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{16'd65520, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{16'd1,     8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd59,    8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd359,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd65535, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd30,    8'd1,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd90,    8'd128, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd210,   8'd255, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd270,   8'd200, 8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd330,   8'd77,  8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd719,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // hue[15:0], saturation[23:16], brightness_value[31:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // red[7:0], green[15:8], blue[23:16]

    bit          calm = 1'b0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    known_rgb_t  known_q[$];
    rgb_t        rgb_due[$];

    hsv_to_rgb_converter_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic rgb_t hsv_to_rgb(hsv_t colour);
        int unsigned         s;
        int unsigned         v;
        int unsigned         ramp;
        int unsigned         p;
        int unsigned         tint;
        int unsigned         vary;
        hsvrgb_pkg::sector_t sector;
        rgb_t                rgb;
        s = colour.saturation;
        v = colour.brightness_value;
        if (s == 0)
        begin
            rgb.red   = CHAN_W'(v);
            rgb.green = CHAN_W'(v);
            rgb.blue  = CHAN_W'(v);
            return rgb;
        end
        sector = hsvrgb_pkg::sector_t'((colour.hue % 360) / 60);
        ramp   = (colour.hue % 60) * 4;
        p      = v * (255 - s) / 255;
        if (sector[0])
            tint = s * ramp / 256;
        else
            tint = s * (256 - ramp) / 256;
        vary = v * (255 - tint) / 255;
        case (sector)
            hsvrgb_pkg::SEC_RED_YEL: rgb = {CHAN_W'(p),    CHAN_W'(vary), CHAN_W'(v)};
            hsvrgb_pkg::SEC_YEL_GRN: rgb = {CHAN_W'(p),    CHAN_W'(v),    CHAN_W'(vary)};
            hsvrgb_pkg::SEC_GRN_CYN: rgb = {CHAN_W'(vary), CHAN_W'(v),    CHAN_W'(p)};
            hsvrgb_pkg::SEC_CYN_BLU: rgb = {CHAN_W'(v),    CHAN_W'(vary), CHAN_W'(p)};
            hsvrgb_pkg::SEC_BLU_MAG: rgb = {CHAN_W'(v),    CHAN_W'(p),    CHAN_W'(vary)};
            default:                 rgb = {CHAN_W'(vary), CHAN_W'(p),    CHAN_W'(v)};
        endcase
        return rgb;
    endfunction

    function automatic hsv_t random_colour();
        hsv_t colour;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: colour.hue = HUE_W'($urandom);
            4, 5:       colour.hue = HUE_W'($urandom_range(0, 359));
            // sector edges across the whole hue range
            6:          colour.hue = HUE_W'(60 * $urandom_range(0, 1091)
                                            + 59 * $urandom_range(0, 1));
            default:    colour.hue = HUE_W'(65535 - $urandom_range(0, 400));
        endcase
        case ($urandom_range(0, 15))
            0, 1:    colour.saturation = '0;
            2, 3:    colour.saturation = '1;
            4:       colour.saturation = CHAN_W'(1);
            default: colour.saturation = CHAN_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       colour.brightness_value = '0;
            1:       colour.brightness_value = '1;
            default: colour.brightness_value = CHAN_W'($urandom);
        endcase
        return colour;
    endfunction

    // entered and left at a falling edge
    task automatic send_colour(input hsv_t colour, input bit pinned, input rgb_t rgb);
        known_rgb_t known;
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        known.pinned = pinned;
        known.rgb    = rgb;
        known_q.push_back(known);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= colour;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin : scoreboard
        known_rgb_t known;
        rgb_t       want;
        rgb_t       got;
        string      chan_name [3];
        chan_name = '{"red", "green", "blue"};
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                known = known_q.pop_front();
                rgb_due.push_back(known.pinned ? known.rgb : hsv_to_rgb(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (rgb_due.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = rgb_due.pop_front();
                    for (int c = 0; c < 3; c++)
                    begin
                        if (got[c*CHAN_W +: CHAN_W] !== want[c*CHAN_W +: CHAN_W])
                        begin
                            $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                                     chan_name[c], want[c*CHAN_W +: CHAN_W],
                                     got[c*CHAN_W +: CHAN_W]);
                            mismatches++;
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        colour_row_t row;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = COLOUR_TABLE[i];
            send_colour({row.val, row.sat, row.hue}, row.pinned,
                        {row.blue, row.green, row.red});
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // back-to-back stretch with no idling on either side
            calm = (i >= 700) && (i < 1000);
            send_colour(random_colour(), 1'b0, '0);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (rgb_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: hsv_to_rgb_converter_core.f
rtl/hsvrgb_pkg.sv
rtl/hsv_to_rgb_converter_core.sv
tb/sv/tb_hsv_to_rgb_converter_core.sv
